### rtl/core/udpst_pkg.sv
// udpst_pkg: shared types and constants of the UDP port / socket table.
// Used by udpst_ctrl, udpst_datapath, udp_port_socket_table_core and the testbench. No dependencies.
`default_nettype none

package udpst_pkg;

   localparam int OP_W       = 2;
   localparam int TASK_W     = 4;
   localparam int SOCK_W     = 8;
   localparam int PORT_W     = 16;
   localparam int TASK_OUT_W = 4;
   localparam int SOCK_OUT_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN      = 2'd0,
      OP_CLOSE     = 2'd1,
      OP_CLOSE_ALL = 2'd2,
      OP_LOOKUP    = 2'd3
   } op_type;

   typedef struct packed {
      logic clear;     // write zeros at sweep counter
      logic load;      // capture request beat
      logic rd;        // read both tables
      logic exec;      // decide and write back
      logic sweep;     // free one port of a close-all
      logic publish;   // move result to output register
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sweep_go;
      logic sweep_last;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

### rtl/core/udp_port_socket_table_core.sv
// udp_port_socket_table_core: top level of the UDP port / socket binding table.
// Depends on udpst_pkg, udpst_ctrl, udpst_datapath (and through it udpst_ram).
//
// After reset the block sweeps both tables to zero with req_ready low; its clear
// counter runs over max(PORT_COUNT, TASK_COUNT) addresses (65536 at the defaults).
// Afterwards one request is handled at a time: open, close and lookup pass through
// accept, table read, decide and write back, and hand to the output register; a
// close-all of a valid task adds a sweep that frees the port of each active slot
// in turn, since the port table has a single write port. The result sits in an
// output register, so the next request is accepted while a result waits; the
// block stalls only when a new result is ready and the previous one is still held.
`default_nettype none

module udp_port_socket_table_core #(
   parameter int TASK_COUNT       = 16,
   parameter int SOCKETS_PER_TASK = 8,
   parameter int PORT_COUNT       = 65536
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [udpst_pkg::OP_W-1:0]       req_op,
   input  wire logic [udpst_pkg::TASK_W-1:0]     req_task_id,
   input  wire logic [udpst_pkg::SOCK_W-1:0]     req_socket_id,
   input  wire logic [udpst_pkg::PORT_W-1:0]     req_port,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_ok,
   output logic      [udpst_pkg::TASK_OUT_W-1:0] rsp_task_out,
   output logic      [udpst_pkg::SOCK_OUT_W-1:0] rsp_socket_out
);

   udpst_pkg::cmd_type cmd;
   udpst_pkg::sts_type sts;

   udpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   udpst_datapath #(
      .TASK_COUNT       (TASK_COUNT),
      .SOCKETS_PER_TASK (SOCKETS_PER_TASK),
      .PORT_COUNT       (PORT_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_task_id    (req_task_id),
      .req_socket_id  (req_socket_id),
      .req_port       (req_port),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_task_out   (rsp_task_out),
      .rsp_socket_out (rsp_socket_out)
   );

endmodule

`default_nettype wire

### rtl/core/udpst_ram.sv
// udpst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module udpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/udpst_ctrl.sv
// udpst_ctrl: sequencer of the UDP port / socket table.
// Depends on udpst_pkg (cmd_type, sts_type).
`default_nettype none

module udpst_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire udpst_pkg::sts_type sts,
   output udpst_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_SWEEP = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.sweep_go ? ST_SWEEP : ST_DONE;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted beat not followed by table read");

   a_sweep_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && sts.sweep_go) |=> (state_ff == ST_SWEEP))
      else $error("close-all did not start its sweep");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !sts.rsp_busy)
      else $error("result published over a pending beat");

endmodule

`default_nettype wire

### rtl/core/udpst_datapath.sv
// udpst_datapath: port table, socket table, clear sweep and result registers.
// Depends on udpst_pkg and udpst_ram.
`default_nettype none

module udpst_datapath #(
   parameter int TASK_COUNT       = 16,
   parameter int SOCKETS_PER_TASK = 8,
   parameter int PORT_COUNT       = 65536
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire udpst_pkg::cmd_type                   cmd,
   output udpst_pkg::sts_type                        sts,
   input  wire logic [udpst_pkg::OP_W-1:0]           req_op,
   input  wire logic [udpst_pkg::TASK_W-1:0]         req_task_id,
   input  wire logic [udpst_pkg::SOCK_W-1:0]         req_socket_id,
   input  wire logic [udpst_pkg::PORT_W-1:0]         req_port,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_ok,
   output logic      [udpst_pkg::TASK_OUT_W-1:0]     rsp_task_out,
   output logic      [udpst_pkg::SOCK_OUT_W-1:0]     rsp_socket_out
);

   localparam int TW        = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int SW        = (SOCKETS_PER_TASK > 1) ? $clog2(SOCKETS_PER_TASK) : 1;
   localparam int PA        = $clog2(PORT_COUNT);
   localparam int EW        = PA + 1;
   localparam int RW        = SOCKETS_PER_TASK * EW;
   localparam int PE        = 1 + TW + SW;
   localparam int CLR_COUNT = (PORT_COUNT > TASK_COUNT) ? PORT_COUNT : TASK_COUNT;
   localparam int CW        = $clog2(CLR_COUNT);
   localparam int TOW       = udpst_pkg::TASK_OUT_W;
   localparam int SOW       = udpst_pkg::SOCK_OUT_W;

   // captured request
   logic [udpst_pkg::OP_W-1:0]   op_ff, op_in;
   logic [udpst_pkg::TASK_W-1:0] task_ff, task_in;
   logic [udpst_pkg::SOCK_W-1:0] sock_ff, sock_in;
   logic [udpst_pkg::PORT_W-1:0] port_ff, port_in;
   udpst_pkg::op_type            op;

   logic          task_ok, sock_ok, port_ok;
   logic [TW+3:0] task_wide;
   logic [SW+7:0] sock_wide;
   logic [TW-1:0] tidx;
   logic [SW-1:0] sidx;
   logic [PA-1:0] pidx;

   // counters and results
   logic [CW-1:0]  clr_ff, clr_in;
   logic [SW-1:0]  idx_ff, idx_in;
   logic           res_ok_ff, res_ok_in;
   logic [TOW-1:0] res_task_ff, res_task_in;
   logic [SOW-1:0] res_sock_ff, res_sock_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [TOW-1:0] rsp_task_ff, rsp_task_in;
   logic [SOW-1:0] rsp_sock_ff, rsp_sock_in;

   // memories
   logic          pt_wr_en, sk_wr_en;
   logic [PA-1:0] pt_wr_addr;
   logic [PE-1:0] pt_wr_data, pt_q;
   logic [TW-1:0] sk_wr_addr;
   logic [RW-1:0] sk_wr_data, sk_q;

   logic          pt_act;
   logic [TW-1:0] pt_task;
   logic [SW-1:0] pt_slot;
   logic [TW+3:0] ptask_wide;
   logic [SW+2:0] pslot_wide;
   logic [SW+2:0] fslot_wide;

   logic [SOCKETS_PER_TASK-1:0] act_vec;
   logic [PA-1:0]               port_vec [SOCKETS_PER_TASK];
   logic                        free_found;
   logic [SW-1:0]               free_idx;
   logic [RW-1:0]               open_row, close_row;
   logic                        open_go, close_go;
   logic                        clr_pt, clr_sk;

   assign op_in   = cmd.load ? req_op : op_ff;
   assign task_in = cmd.load ? req_task_id : task_ff;
   assign sock_in = cmd.load ? req_socket_id : sock_ff;
   assign port_in = cmd.load ? req_port : port_ff;

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      task_ff <= task_in;
      sock_ff <= sock_in;
      port_ff <= port_in;
   end

   assign op        = udpst_pkg::op_type'(op_ff);
   assign task_ok   = {5'b0, task_ff} < 9'(TASK_COUNT);
   assign sock_ok   = {1'b0, sock_ff} < 9'(SOCKETS_PER_TASK);
   assign port_ok   = {1'b0, port_ff} < 17'(PORT_COUNT);
   assign task_wide = {{TW{1'b0}}, task_ff};
   assign sock_wide = {{SW{1'b0}}, sock_ff};
   assign tidx      = task_wide[TW-1:0];
   assign sidx      = sock_wide[SW-1:0];
   assign pidx      = port_ff[PA-1:0];

   udpst_ram #(
      .WIDTH (PE),
      .DEPTH (PORT_COUNT)
   ) u_port_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (pidx),
      .rd_data (pt_q)
   );

   udpst_ram #(
      .WIDTH (RW),
      .DEPTH (TASK_COUNT)
   ) u_sock_ram (
      .clock   (clock),
      .wr_en   (sk_wr_en),
      .wr_addr (sk_wr_addr),
      .wr_data (sk_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (tidx),
      .rd_data (sk_q)
   );

   // port entry: {active, task, slot}
   assign pt_act     = pt_q[SW+TW];
   assign pt_task    = pt_q[SW +: TW];
   assign pt_slot    = pt_q[SW-1:0];
   assign ptask_wide = {4'b0, pt_task};
   assign pslot_wide = {3'b0, pt_slot};
   assign fslot_wide = {3'b0, free_idx};

   // socket row: one {active, port} entry per slot
   always_comb begin
      for (int i = 0; i < SOCKETS_PER_TASK; i++) begin
         act_vec[i]  = sk_q[i*EW + PA];
         port_vec[i] = sk_q[i*EW +: PA];
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SOCKETS_PER_TASK - 1; i >= 0; i--) begin
         if (!act_vec[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SOCKETS_PER_TASK; i++) begin
         open_row[i*EW +: EW]  = (free_idx == SW'(i)) ? {1'b1, pidx} : sk_q[i*EW +: EW];
         close_row[i*EW +: EW] = (sidx == SW'(i)) ? {EW{1'b0}} : sk_q[i*EW +: EW];
      end
   end

   assign open_go  = task_ok && port_ok && !pt_act && free_found;
   assign close_go = task_ok && sock_ok;
   assign clr_pt   = {1'b0, clr_ff} < (CW+1)'(PORT_COUNT);
   assign clr_sk   = {1'b0, clr_ff} < (CW+1)'(TASK_COUNT);

   always_comb begin
      pt_wr_en    = 1'b0;
      pt_wr_addr  = pidx;
      pt_wr_data  = '0;
      sk_wr_en    = 1'b0;
      sk_wr_addr  = tidx;
      sk_wr_data  = '0;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      res_ok_in   = res_ok_ff;
      res_task_in = res_task_ff;
      res_sock_in = res_sock_ff;
      if (cmd.clear) begin
         pt_wr_en   = clr_pt;
         pt_wr_addr = clr_ff[PA-1:0];
         sk_wr_en   = clr_sk;
         sk_wr_addr = clr_ff[TW-1:0];
         clr_in     = clr_ff + 1'b1;
      end
      if (cmd.exec) begin
         res_ok_in   = 1'b0;
         res_task_in = '0;
         res_sock_in = '0;
         idx_in      = '0;
         case (op)
            udpst_pkg::OP_OPEN: begin
               if (open_go) begin
                  pt_wr_en    = 1'b1;
                  pt_wr_data  = {1'b1, tidx, free_idx};
                  sk_wr_en    = 1'b1;
                  sk_wr_data  = open_row;
                  res_ok_in   = 1'b1;
                  res_sock_in = fslot_wide[SOW-1:0];
               end
            end
            udpst_pkg::OP_CLOSE: begin
               if (close_go) begin
                  res_ok_in = 1'b1;
                  if (act_vec[sidx]) begin
                     pt_wr_en   = 1'b1;
                     pt_wr_addr = port_vec[sidx];
                     sk_wr_en   = 1'b1;
                     sk_wr_data = close_row;
                  end
               end
            end
            udpst_pkg::OP_CLOSE_ALL: begin
               if (task_ok) begin
                  res_ok_in = 1'b1;
                  sk_wr_en  = 1'b1;
               end
            end
            udpst_pkg::OP_LOOKUP: begin
               if (port_ok && pt_act) begin
                  res_ok_in   = 1'b1;
                  res_task_in = ptask_wide[TOW-1:0];
                  res_sock_in = pslot_wide[SOW-1:0];
               end
            end
            default: begin
               res_ok_in = 1'b0;
            end
         endcase
      end
      // row read data holds during the sweep: freed ports come from it
      if (cmd.sweep) begin
         pt_wr_en   = act_vec[idx_ff];
         pt_wr_addr = port_vec[idx_ff];
         idx_in     = idx_ff + 1'b1;
      end
   end

   assign rsp_ok_in   = cmd.publish ? res_ok_ff : rsp_ok_ff;
   assign rsp_task_in = cmd.publish ? res_task_ff : rsp_task_ff;
   assign rsp_sock_in = cmd.publish ? res_sock_ff : rsp_sock_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      res_ok_ff   <= res_ok_in;
      res_task_ff <= res_task_in;
      res_sock_ff <= res_sock_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_task_ff <= rsp_task_in;
      rsp_sock_ff <= rsp_sock_in;
   end

   assign sts.clr_last   = (clr_ff == CW'(CLR_COUNT - 1));
   assign sts.sweep_go   = (op == udpst_pkg::OP_CLOSE_ALL) && task_ok;
   assign sts.sweep_last = (idx_ff == SW'(SOCKETS_PER_TASK - 1));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_task_out   = rsp_task_ff;
   assign rsp_socket_out = rsp_sock_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_task_ff == '0 && rsp_sock_ff == '0))
      else $error("failed result carries nonzero task or slot");

   a_sweep_op: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> (op == udpst_pkg::OP_CLOSE_ALL && task_ok))
      else $error("port sweep outside a valid close-all");

   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result valid rose without publish");

endmodule

`default_nettype wire

### tb/tb_udp_port_socket_table_core.sv
// tb_udp_port_socket_table_core: self-checking bench for the UDP port / socket table.
// Depends on udpst_pkg and udp_port_socket_table_core; predicts each result beat
// from its own copy of the port and slot tables and checks responses in order.
`timescale 1ns / 1ps

module tb_udp_port_socket_table_core;

   localparam int TASKS = 16;
   localparam int SLOTS = 8;
   localparam int PORTS = 65536;
   localparam int POOL  = 48;

   typedef struct packed {
      udpst_pkg::op_type                 op;
      logic [udpst_pkg::TASK_W-1:0]      task_id;
      logic [udpst_pkg::SOCK_W-1:0]      socket_id;
      logic [udpst_pkg::PORT_W-1:0]      port;
   } sock_req_type;

   typedef struct packed {
      logic                              ok;
      logic [udpst_pkg::TASK_OUT_W-1:0]  task_out;
      logic [udpst_pkg::SOCK_OUT_W-1:0]  socket_out;
   } sock_rsp_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [udpst_pkg::OP_W-1:0]        req_op = '0;
   logic [udpst_pkg::TASK_W-1:0]      req_task_id = '0;
   logic [udpst_pkg::SOCK_W-1:0]      req_socket_id = '0;
   logic [udpst_pkg::PORT_W-1:0]      req_port = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_ok;
   logic [udpst_pkg::TASK_OUT_W-1:0]  rsp_task_out;
   logic [udpst_pkg::SOCK_OUT_W-1:0]  rsp_socket_out;

   // predicted tables
   bit                                bind_active [PORTS];
   bit [udpst_pkg::TASK_OUT_W-1:0]    bind_task   [PORTS];
   bit [udpst_pkg::SOCK_OUT_W-1:0]    bind_slot   [PORTS];
   bit                                slot_active [TASKS][SLOTS];
   bit [udpst_pkg::PORT_W-1:0]        slot_port   [TASKS][SLOTS];

   sock_req_type   pending[$];
   sock_rsp_type   expected[$];
   sock_rsp_type   want;
   sock_req_type   nxt;
   bit [15:0]      port_pool [POOL];
   bit             req_taken = 1'b0;
   bit             hold_rsp = 1'b0;
   int             errors = 0;
   int             n_queued = 0;
   int             n_accepted = 0;
   int             n_results = 0;
   int             n_binds = 0;
   int             n_hits = 0;
   int             n_frees = 0;

   udp_port_socket_table_core #(
      .TASK_COUNT(TASKS),
      .SOCKETS_PER_TASK(SLOTS),
      .PORT_COUNT(PORTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_task_id(req_task_id),
      .req_socket_id(req_socket_id),
      .req_port(req_port),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_task_out(rsp_task_out),
      .rsp_socket_out(rsp_socket_out)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
   endtask

   function automatic void unbind_slot(input int t, input int s);
      if (slot_active[t][s]) begin
         if (int'(slot_port[t][s]) < PORTS) bind_active[slot_port[t][s]] = 1'b0;
         slot_active[t][s] = 1'b0;
         n_frees++;
      end
   endfunction

   function automatic sock_rsp_type socket_table_update(input sock_req_type r);
      sock_rsp_type res;
      int           s;
      int           t;
      bit           t_ok;
      res  = '0;
      t    = int'(r.task_id);
      t_ok = t < TASKS;
      case (r.op)
         udpst_pkg::OP_OPEN: begin
            if (t_ok && int'(r.port) < PORTS && !bind_active[r.port]) begin
               for (s = 0; s < SLOTS && !res.ok; s++) begin
                  if (!slot_active[t][s]) begin
                     slot_active[t][s]     = 1'b1;
                     slot_port[t][s]       = r.port;
                     bind_active[r.port]   = 1'b1;
                     bind_task[r.port]     = r.task_id;
                     bind_slot[r.port]     = s[udpst_pkg::SOCK_OUT_W-1:0];
                     res.ok                = 1'b1;
                     res.socket_out        = s[udpst_pkg::SOCK_OUT_W-1:0];
                     n_binds++;
                  end
               end
            end
         end
         udpst_pkg::OP_CLOSE: begin
            if (t_ok && int'(r.socket_id) < SLOTS) begin
               unbind_slot(t, int'(r.socket_id));
               res.ok = 1'b1;
            end
         end
         udpst_pkg::OP_CLOSE_ALL: begin
            if (t_ok) begin
               for (s = 0; s < SLOTS; s++) unbind_slot(t, s);
               res.ok = 1'b1;
            end
         end
         default: begin
            if (int'(r.port) < PORTS && bind_active[r.port]) begin
               res.ok         = 1'b1;
               res.task_out   = bind_task[r.port];
               res.socket_out = bind_slot[r.port];
               n_hits++;
            end
         end
      endcase
      return res;
   endfunction

   task automatic queue_request(input udpst_pkg::op_type op, input int t, input int s,
                                input int p);
      sock_req_type r;
      r.op        = op;
      r.task_id   = t[udpst_pkg::TASK_W-1:0];
      r.socket_id = s[udpst_pkg::SOCK_W-1:0];
      r.port      = p[udpst_pkg::PORT_W-1:0];
      pending.push_back(r);
      n_queued++;
   endtask

   task automatic queue_random(input int count);
      int                i;
      int                k;
      int                t;
      int                p;
      int                s;
      udpst_pkg::op_type op;
      for (i = 0; i < count; i++) begin
         k  = $urandom_range(99);
         if (k < 35) begin
            op = udpst_pkg::OP_OPEN;
         end else if (k < 55) begin
            op = udpst_pkg::OP_CLOSE;
         end else if (k < 60) begin
            op = udpst_pkg::OP_CLOSE_ALL;
         end else begin
            op = udpst_pkg::OP_LOOKUP;
         end
         t  = $urandom_range(99) < 50 ? $urandom_range(3) : $urandom_range(TASKS - 1);
         p  = $urandom_range(99) < 85 ? port_pool[$urandom_range(POOL - 1)]
                                      : $urandom_range(PORTS - 1);
         s  = $urandom_range(99) < 85 ? $urandom_range(SLOTS - 1) : $urandom_range(255);
         queue_request(op, t, s, p);
         // open followed by a lookup of the same port
         if (op == udpst_pkg::OP_OPEN && $urandom_range(99) < 40) begin
            queue_request(udpst_pkg::OP_LOOKUP, $urandom_range(15), $urandom_range(255), p);
            i++;
         end
      end
   endtask

   task automatic wait_drained;
      while (n_accepted != n_queued || expected.size() != 0) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_rsp &&
                      ((n_results >= 600 && n_results < 800) || $urandom_range(99) >= 17);
         if (req_taken || !req_valid) begin
            req_taken = 1'b0;
            if (pending.size() != 0 &&
                ((n_accepted >= 600 && n_accepted < 800) || $urandom_range(99) >= 17)) begin
               nxt = pending.pop_front();
               req_op        <= nxt.op;
               req_task_id   <= nxt.task_id;
               req_socket_id <= nxt.socket_id;
               req_port      <= nxt.port;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = expected.pop_front();
               if (rsp_ok !== want.ok)
                  report_mismatch($sformatf("beat %0d ok %b, predicted %b",
                                            n_results, rsp_ok, want.ok));
               if (rsp_task_out !== want.task_out)
                  report_mismatch($sformatf("beat %0d task_out %0d, predicted %0d",
                                            n_results, rsp_task_out, want.task_out));
               if (rsp_socket_out !== want.socket_out)
                  report_mismatch($sformatf("beat %0d socket_out %0d, predicted %0d",
                                            n_results, rsp_socket_out, want.socket_out));
            end
         end
         if (req_valid && req_ready) begin
            expected.push_back(socket_table_update(sock_req_type'(
               {udpst_pkg::op_type'(req_op), req_task_id, req_socket_id, req_port})));
            n_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      while (n_results < 120) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d of %0d requests accepted, %0d results outstanding",
               n_accepted, n_queued, expected.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int i;
      for (i = 0; i < POOL; i++) port_pool[i] = $urandom_range(PORTS - 1);
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hffff;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: bounds, collisions, full task, close corner cases
      queue_request(udpst_pkg::OP_OPEN, 0, 0, 0);
      queue_request(udpst_pkg::OP_OPEN, 15, 255, 65535);
      queue_request(udpst_pkg::OP_OPEN, 3, 0, 0);
      queue_request(udpst_pkg::OP_LOOKUP, 7, 0, 0);
      queue_request(udpst_pkg::OP_LOOKUP, 0, 0, 65535);
      queue_request(udpst_pkg::OP_LOOKUP, 0, 0, 1234);
      for (i = 0; i < SLOTS; i++) queue_request(udpst_pkg::OP_OPEN, 5, 0, 100 + i);
      queue_request(udpst_pkg::OP_OPEN, 5, 0, 108);
      queue_request(udpst_pkg::OP_CLOSE, 5, 3, 0);
      queue_request(udpst_pkg::OP_CLOSE, 5, 3, 0);
      queue_request(udpst_pkg::OP_CLOSE, 5, 8, 0);
      queue_request(udpst_pkg::OP_CLOSE, 5, 255, 0);
      queue_request(udpst_pkg::OP_OPEN, 5, 0, 200);
      queue_request(udpst_pkg::OP_LOOKUP, 0, 0, 103);
      queue_request(udpst_pkg::OP_CLOSE_ALL, 5, 0, 0);
      queue_request(udpst_pkg::OP_CLOSE_ALL, 9, 0, 0);
      queue_request(udpst_pkg::OP_LOOKUP, 0, 0, 200);
      queue_request(udpst_pkg::OP_CLOSE, 15, 0, 0);
      wait_drained();

      queue_random(500);
      wait_drained();
      queue_random(580);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("covered %0d requests and %0d result beats: %0d binds, %0d slots freed,",
               n_accepted, n_results, n_binds, n_frees);
      $display("%0d lookups found, with stalls, a long output hold-off and idle drains",
               n_hits);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/udpst_pkg.sv
rtl/core/udpst_ram.sv
rtl/core/udpst_ctrl.sv
rtl/core/udpst_datapath.sv
rtl/core/udp_port_socket_table_core.sv
tb/tb_udp_port_socket_table_core.sv
